// ===== rtl/cdts_pkg.sv =====
package cdts_pkg;

  localparam int FRAC    = 16;
  localparam int OMG_SH  = 17;

  localparam int TL_W    = 17;
  localparam int DT_W    = 16;
  localparam int ST_W    = 20;
  localparam int VEL_W   = 21;
  localparam int X_W     = 23;
  localparam int X2_W    = 29;
  localparam int X3_W    = 35;
  localparam int DEN_W   = 33;
  localparam int DEC_W   = 17;
  localparam int CH_W    = 18;
  localparam int TMP_W   = 34;
  localparam int W_W     = 38;
  localparam int NV_W    = 39;
  localparam int GOAL_W  = 19;
  localparam int OD_W    = 36;
  localparam int OUT_W   = 37;
  localparam int MAXC_W  = 22;

  localparam int DD_W    = 51;
  localparam int DV_W    = 33;
  localparam int WD_W    = DD_W + 2;

  localparam int MA_W    = 38;
  localparam int MB_W    = 24;
  localparam int MP_W    = MA_W + MB_W;

  localparam int IN_TD_W  = 40;
  localparam int OUT_TD_W = 24;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 20;

  localparam logic [CFG_IW-1:0] REG_SMOOTH_TIME = 2'd0;
  localparam logic [CFG_IW-1:0] REG_LOW_THR     = 2'd1;

  localparam logic [ST_W-1:0]   ST_MIN      = 20'd7;
  localparam logic [TL_W-1:0]   THR_RESET   = 17'd19661;
  localparam logic [X_W-1:0]    X_MAX       = 23'h40_0000;
  localparam logic [14:0]       COEF_SQ     = 15'd31457;
  localparam logic [13:0]       COEF_CU     = 14'd15401;
  localparam logic [DEN_W-1:0]  UNITY       = 33'd65536;
  localparam logic [DD_W-1:0]   DEC_BASE    = 51'h1_0000_0000;
  localparam logic signed [W_W-1:0]   W_MAX   = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0]   W_MIN   = {1'b1, {(W_W-1){1'b0}}};
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic [TL_W-1:0]   POS_MAX     = {TL_W{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE,
    S_X_GO,
    S_X_WAIT,
    S_SQ,
    S_CU,
    S_C2,
    S_C3,
    S_DEN,
    S_DEC_GO,
    S_DEC_WAIT,
    S_CH_GO,
    S_CH_WAIT,
    S_MT,
    S_TMP,
    S_TP_GO,
    S_TP_WAIT,
    S_MV,
    S_MO,
    S_OUT,
    S_FIN
  } cdts_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cdts_div_sts_t;

endpackage

// ===== rtl/cdts_mul.sv =====
module cdts_mul (
  input  logic                                clk,
  input  logic signed [cdts_pkg::MA_W-1:0]    a,
  input  logic signed [cdts_pkg::MB_W-1:0]    b,
  output logic signed [cdts_pkg::MP_W-1:0]    p_r
);

  localparam int MP_W = cdts_pkg::MP_W;

  logic signed [MP_W-1:0] p_nxt;

  assign p_nxt = a * b;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// ===== rtl/cdts_div.sv =====
module cdts_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [cdts_pkg::DD_W-1:0]      dividend,
  input  logic [cdts_pkg::DV_W-1:0]      divisor,
  output logic [cdts_pkg::DD_W-1:0]      quotient,
  output cdts_pkg::cdts_div_sts_t        sts
);

  localparam int DD_W  = cdts_pkg::DD_W;
  localparam int DV_W  = cdts_pkg::DV_W;
  localparam int CNT_W = $clog2(DD_W);

  logic [DV_W-1:0]  rem_r, rem_nxt;
  logic [DV_W-1:0]  dvs_r;
  logic [DD_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DV_W:0]    trial;
  logic [DV_W:0]    diff;
  logic             fits;

  assign trial    = {rem_r, quo_r[DD_W-1]};
  assign fits     = trial >= {1'b0, dvs_r};
  assign diff     = trial - {1'b0, dvs_r};
  assign rem_nxt  = fits ? diff[DV_W-1:0] : trial[DV_W-1:0];
  assign quo_nxt  = {quo_r[DD_W-2:0], fits};
  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && cnt_r == '0 |=> done_r && !busy_r)
    else $error("divider did not finish after its last step");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

// ===== rtl/critically_damped_trail_smoother.sv =====
// A spring step runs the shared radix-2 divider four times between input transfer
//   and result valid; the sequencer launches each run and takes its quotient.
// A zero time step or a zero smoothing time skips the spring step and goes to S_FIN.
// A new item is not taken while a step is in progress;
//   the next item is taken once the result is registered.
// Reset (rst_n low, synchronous): trail and velocity clear, smooth_time 0,
//   low_threshold 19661, output channel empty.
module critically_damped_trail_smoother (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cdts_pkg::IN_TD_W-1:0]       in_tdata,   // target_level[16:0], time_step[32:17]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cdts_pkg::OUT_TD_W-1:0]      out_tdata,  // trail_level[16:0]
  output logic [0:0]                         out_tuser,  // low_warning[0]
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cdts_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [cdts_pkg::CFG_DW-1:0]        cfg_data
);

  localparam int FRAC     = cdts_pkg::FRAC;
  localparam int OMG_SH   = cdts_pkg::OMG_SH;
  localparam int TL_W     = cdts_pkg::TL_W;
  localparam int DT_W     = cdts_pkg::DT_W;
  localparam int ST_W     = cdts_pkg::ST_W;
  localparam int VEL_W    = cdts_pkg::VEL_W;
  localparam int X_W      = cdts_pkg::X_W;
  localparam int X2_W     = cdts_pkg::X2_W;
  localparam int X3_W     = cdts_pkg::X3_W;
  localparam int DEN_W    = cdts_pkg::DEN_W;
  localparam int DEC_W    = cdts_pkg::DEC_W;
  localparam int CH_W     = cdts_pkg::CH_W;
  localparam int TMP_W    = cdts_pkg::TMP_W;
  localparam int W_W      = cdts_pkg::W_W;
  localparam int NV_W     = cdts_pkg::NV_W;
  localparam int GOAL_W   = cdts_pkg::GOAL_W;
  localparam int OD_W     = cdts_pkg::OD_W;
  localparam int OUT_W    = cdts_pkg::OUT_W;
  localparam int MAXC_W   = cdts_pkg::MAXC_W;
  localparam int DD_W     = cdts_pkg::DD_W;
  localparam int DV_W     = cdts_pkg::DV_W;
  localparam int WD_W     = cdts_pkg::WD_W;
  localparam int MA_W     = cdts_pkg::MA_W;
  localparam int MB_W     = cdts_pkg::MB_W;
  localparam int MP_W     = cdts_pkg::MP_W;
  localparam int OUT_TD_W = cdts_pkg::OUT_TD_W;

  cdts_pkg::cdts_state_t state_r, state_nxt;

  logic [ST_W-1:0]          st_r;
  logic [TL_W-1:0]          thr_r;
  logic [TL_W-1:0]          pos_r;
  logic signed [VEL_W-1:0]  vel_r;

  logic [TL_W-1:0]          tgt_r;
  logic [DT_W-1:0]          dt_r;
  logic                     low_r;
  logic [ST_W-1:0]          eff_r;
  logic [X_W-1:0]           x_r;
  logic [X2_W-1:0]          x2_r;
  logic [X3_W-1:0]          x3_r;
  logic [DEN_W-1:0]         den_r;
  logic [DEC_W-1:0]         dec_r;
  logic signed [CH_W-1:0]   chg_r;
  logic signed [TMP_W-1:0]  sum_r;
  logic signed [TMP_W-1:0]  tmp_r;
  logic signed [W_W-1:0]    w_r;
  logic signed [NV_W-1:0]   nv_r;

  logic                     out_valid_r;
  logic [TL_W-1:0]          out_trail_r;
  logic                     out_low_r;
  logic                     out_load;

  logic                     in_acc;
  logic [TL_W-1:0]          in_tgt;
  logic [DT_W-1:0]          in_dt;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MP_W-1:0]   mul_p;

  logic                     div_start;
  logic [DD_W-1:0]          div_dd;
  logic [DV_W-1:0]          div_dv;
  logic [DD_W-1:0]          div_quo;
  cdts_pkg::cdts_div_sts_t  div_sts;

  logic signed [CH_W-1:0]   diff;
  logic signed [MAXC_W-1:0] diff_x;
  logic signed [MAXC_W-1:0] maxc;
  logic signed [MAXC_W-1:0] neg_maxc;
  logic signed [CH_W-1:0]   chg_clmp;
  logic [CH_W-1:0]          chg_mag;
  logic [TMP_W-1:0]         tmp_mag;
  logic [X_W-1:0]           x_sat;
  logic [DEN_W-1:0]         den_c3;
  logic signed [TMP_W-1:0]  q1s;
  logic signed [TMP_W-1:0]  sum_nxt;
  logic signed [WD_W-1:0]   q2s;
  logic signed [WD_W-1:0]   wd;
  logic signed [W_W-1:0]    w_sat;
  logic signed [GOAL_W-1:0] goal;
  logic signed [OUT_W-1:0]  outv;
  logic                     up;
  logic                     over;
  logic [TL_W-1:0]          pos_sat;
  logic signed [VEL_W-1:0]  vel_sat;

  cdts_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  cdts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dd),
    .divisor  (div_dv),
    .quotient (div_quo),
    .sts      (div_sts)
  );

  assign in_acc     = in_tvalid && in_tready;
  assign in_tgt     = in_tdata[TL_W-1:0];
  assign in_dt      = in_tdata[TL_W +: DT_W];
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TD_W'(out_trail_r);
  assign out_tuser  = out_low_r;
  assign out_load   = (state_r == cdts_pkg::S_FIN) && (!out_valid_r || out_tready);

  // step arithmetic
  assign diff     = $signed({1'b0, pos_r}) - $signed({1'b0, tgt_r});
  assign diff_x   = MAXC_W'(diff);
  assign maxc     = $signed({1'b0, eff_r, 1'b0});
  assign neg_maxc = -maxc;
  assign chg_clmp = (diff_x > maxc)     ? maxc[CH_W-1:0] :
                    (diff_x < neg_maxc) ? neg_maxc[CH_W-1:0] : diff;
  assign chg_mag  = chg_r[CH_W-1] ? CH_W'(-chg_r) : CH_W'(chg_r);
  assign tmp_mag  = tmp_r[TMP_W-1] ? TMP_W'(-tmp_r) : TMP_W'(tmp_r);
  assign x_sat    = (div_quo > DD_W'(cdts_pkg::X_MAX)) ? cdts_pkg::X_MAX : div_quo[X_W-1:0];
  assign den_c3   = cdts_pkg::UNITY + DEN_W'(x_r) + mul_p[FRAC +: DEN_W];
  assign q1s      = $signed({1'b0, div_quo[TMP_W-2:0]});
  assign sum_nxt  = TMP_W'(vel_r) + (chg_r[CH_W-1] ? -q1s : q1s);
  assign q2s      = $signed({2'b00, div_quo});
  assign wd       = WD_W'(vel_r) - (tmp_r[TMP_W-1] ? -q2s : q2s);
  assign w_sat    = (wd > WD_W'(cdts_pkg::W_MAX)) ? cdts_pkg::W_MAX :
                    (wd < WD_W'(cdts_pkg::W_MIN)) ? cdts_pkg::W_MIN : wd[W_W-1:0];
  assign goal     = $signed({2'b00, pos_r}) - GOAL_W'(chg_r);
  assign outv     = OUT_W'(goal) + OUT_W'($signed(mul_p[FRAC +: OD_W]));
  assign up       = tgt_r > pos_r;
  assign over     = outv > $signed({{(OUT_W-TL_W){1'b0}}, tgt_r});
  assign pos_sat  = (outv < 0) ? '0 :
                    (outv > $signed({{(OUT_W-TL_W){1'b0}}, cdts_pkg::POS_MAX})) ?
                    cdts_pkg::POS_MAX : outv[TL_W-1:0];
  assign vel_sat  = (nv_r > NV_W'(cdts_pkg::VEL_MAX)) ? cdts_pkg::VEL_MAX :
                    (nv_r < NV_W'(cdts_pkg::VEL_MIN)) ? cdts_pkg::VEL_MIN : nv_r[VEL_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdts_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_dt == '0 || st_r == '0) ? cdts_pkg::S_FIN : cdts_pkg::S_X_GO;
        end
      end
      cdts_pkg::S_X_GO:     state_nxt = cdts_pkg::S_X_WAIT;
      cdts_pkg::S_X_WAIT:   if (div_sts.done) state_nxt = cdts_pkg::S_SQ;
      cdts_pkg::S_SQ:       state_nxt = cdts_pkg::S_CU;
      cdts_pkg::S_CU:       state_nxt = cdts_pkg::S_C2;
      cdts_pkg::S_C2:       state_nxt = cdts_pkg::S_C3;
      cdts_pkg::S_C3:       state_nxt = cdts_pkg::S_DEN;
      cdts_pkg::S_DEN:      state_nxt = cdts_pkg::S_DEC_GO;
      cdts_pkg::S_DEC_GO:   state_nxt = cdts_pkg::S_DEC_WAIT;
      cdts_pkg::S_DEC_WAIT: if (div_sts.done) state_nxt = cdts_pkg::S_CH_GO;
      cdts_pkg::S_CH_GO:    state_nxt = cdts_pkg::S_CH_WAIT;
      cdts_pkg::S_CH_WAIT:  if (div_sts.done) state_nxt = cdts_pkg::S_MT;
      cdts_pkg::S_MT:       state_nxt = cdts_pkg::S_TMP;
      cdts_pkg::S_TMP:      state_nxt = cdts_pkg::S_TP_GO;
      cdts_pkg::S_TP_GO:    state_nxt = cdts_pkg::S_TP_WAIT;
      cdts_pkg::S_TP_WAIT:  if (div_sts.done) state_nxt = cdts_pkg::S_MV;
      cdts_pkg::S_MV:       state_nxt = cdts_pkg::S_MO;
      cdts_pkg::S_MO:       state_nxt = cdts_pkg::S_OUT;
      cdts_pkg::S_OUT:      state_nxt = cdts_pkg::S_FIN;
      cdts_pkg::S_FIN:      if (!out_valid_r || out_tready) state_nxt = cdts_pkg::S_IDLE;
      default:              state_nxt = cdts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    div_dd    = '0;
    div_dv    = DV_W'(eff_r);
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      cdts_pkg::S_IDLE: in_tready = 1'b1;
      cdts_pkg::S_X_GO: begin
        div_start = 1'b1;
        div_dd    = DD_W'({dt_r, {OMG_SH{1'b0}}});
      end
      cdts_pkg::S_SQ: begin
        mul_a = MA_W'(x_r);
        mul_b = MB_W'(x_r);
      end
      cdts_pkg::S_CU: begin
        mul_a = MA_W'(mul_p[FRAC +: X2_W]);
        mul_b = MB_W'(x_r);
      end
      cdts_pkg::S_C2: begin
        mul_a = MA_W'(x2_r);
        mul_b = MB_W'(cdts_pkg::COEF_SQ);
      end
      cdts_pkg::S_C3: begin
        mul_a = MA_W'(x3_r);
        mul_b = MB_W'(cdts_pkg::COEF_CU);
      end
      cdts_pkg::S_DEC_GO: begin
        div_start = 1'b1;
        div_dd    = cdts_pkg::DEC_BASE + DD_W'(den_r >> 1);
        div_dv    = den_r;
      end
      cdts_pkg::S_CH_GO: begin
        div_start = 1'b1;
        div_dd    = DD_W'({chg_mag, {OMG_SH{1'b0}}});
      end
      cdts_pkg::S_MT: begin
        mul_a = MA_W'(sum_r);
        mul_b = MB_W'(dt_r);
      end
      cdts_pkg::S_TP_GO: begin
        div_start = 1'b1;
        div_dd    = DD_W'({tmp_mag, {OMG_SH{1'b0}}});
      end
      cdts_pkg::S_MV: begin
        mul_a = w_r;
        mul_b = MB_W'(dec_r);
      end
      cdts_pkg::S_MO: begin
        mul_a = MA_W'(chg_r) + MA_W'(tmp_r);
        mul_b = MB_W'(dec_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdts_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      thr_r       <= cdts_pkg::THR_RESET;
      pos_r       <= '0;
      vel_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cdts_pkg::REG_SMOOTH_TIME: st_r  <= cfg_data[ST_W-1:0];
          cdts_pkg::REG_LOW_THR:     thr_r <= cfg_data[TL_W-1:0];
          default: ;
        endcase
      end
      if (state_r == cdts_pkg::S_IDLE && in_acc && in_dt != '0 && st_r == '0) begin
        pos_r <= in_tgt;
        vel_r <= '0;
      end else if (state_r == cdts_pkg::S_OUT) begin
        if (up == over) begin
          pos_r <= tgt_r;
          vel_r <= '0;
        end else begin
          pos_r <= pos_sat;
          vel_r <= vel_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_trail_r <= pos_r;
      out_low_r   <= low_r;
    end
    case (state_r)
      cdts_pkg::S_IDLE: begin
        if (in_acc) begin
          tgt_r <= in_tgt;
          dt_r  <= in_dt;
          low_r <= in_tgt <= thr_r;
          eff_r <= (st_r < cdts_pkg::ST_MIN) ? cdts_pkg::ST_MIN : st_r;
        end
      end
      cdts_pkg::S_X_GO:     chg_r <= chg_clmp;
      cdts_pkg::S_X_WAIT:   if (div_sts.done) x_r <= x_sat;
      cdts_pkg::S_CU:       x2_r <= mul_p[FRAC +: X2_W];
      cdts_pkg::S_C2:       x3_r <= mul_p[FRAC +: X3_W];
      cdts_pkg::S_C3:       den_r <= den_c3;
      cdts_pkg::S_DEN:      den_r <= den_r + mul_p[FRAC +: DEN_W];
      cdts_pkg::S_DEC_WAIT: if (div_sts.done) dec_r <= div_quo[DEC_W-1:0];
      cdts_pkg::S_CH_WAIT:  if (div_sts.done) sum_r <= sum_nxt;
      cdts_pkg::S_TMP:      tmp_r <= $signed(mul_p[FRAC +: TMP_W]);
      cdts_pkg::S_TP_WAIT:  if (div_sts.done) w_r <= w_sat;
      cdts_pkg::S_MO:       nv_r <= $signed(mul_p[FRAC +: NV_W]);
      default: ;
    endcase
  end

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cdts_pkg::S_IDLE |-> !div_sts.busy)
    else $error("divider busy while sequencer idle");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == cdts_pkg::S_X_WAIT || state_r == cdts_pkg::S_DEC_WAIT ||
                      state_r == cdts_pkg::S_CH_WAIT || state_r == cdts_pkg::S_TP_WAIT))
    else $error("divider result arrived outside a wait state");

  a_zero_dt: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_dt == '0 |=> state_r == cdts_pkg::S_FIN)
    else $error("zero time step did not skip the spring step");

  a_snap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_dt != '0 && st_r == '0 |=> pos_r == $past(in_tgt) && vel_r == '0)
    else $error("zero smoothing time did not snap the trail");

endmodule
